// File: src/pvt_pkg.sv
// pvt_pkg: shared types and constants for the presence validation trigger
// beat structs, register indexes, record codes and default parameter values
// no dependencies
package pvt_pkg;

    // fixed field widths
    localparam int TIME_US_W   = 48;
    localparam int SCORE_W     = 7;
    localparam int CLASS_W     = 8;
    localparam int KIND_W      = 2;
    localparam int COUNT_W     = 8;
    localparam int PHASE_W     = 2;
    localparam int SEC_W       = 6;
    // ticks per second up to 1e9 fits in 30 bits
    localparam int TICK_W      = 30;
    localparam int NEED_W      = SEC_W + TICK_W;

    // parameter defaults
    localparam int DEF_TIME_BITS        = 48;
    localparam int DEF_TICKS_PER_SECOND = 1000000;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_CLASS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALIDATE_SECONDS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_SECONDS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_SECONDS = 3'd4;

    // register reset values
    localparam logic [SCORE_W-1:0] RST_SCORE_THRESHOLD  = 7'd75;
    localparam logic [CLASS_W-1:0] RST_TARGET_CLASS     = 8'd0;
    localparam logic [SEC_W-1:0]   RST_VALIDATE_SECONDS = 6'd2;
    localparam logic [SEC_W-1:0]   RST_DEBOUNCE_SECONDS = 6'd1;
    localparam logic [SEC_W-1:0]   RST_COOLDOWN_SECONDS = 6'd8;

    // beat modes
    localparam logic MODE_RECORD    = 1'b0;
    localparam logic MODE_FRAME_END = 1'b1;

    // record kinds
    localparam logic [KIND_W-1:0] KIND_BOX      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLASS    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_KEYPOINT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_INVALID  = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    typedef struct packed {
        logic                 mode;
        logic [KIND_W-1:0]    record_kind;
        logic [CLASS_W-1:0]   record_target;
        logic [SCORE_W-1:0]   record_score;
        logic [TIME_US_W-1:0] time_us;
    } t_in_beat;

    typedef struct packed {
        logic               wake;
        logic [KIND_W-1:0]  frame_kind;
        logic [COUNT_W-1:0] match_count;
        logic [PHASE_W-1:0] phase;
    } t_out_beat;

endpackage

// File: src/pvt_elapsed.sv
// pvt_elapsed: wrapping time difference compared against seconds * tick rate
// uses pvt_pkg for widths
module pvt_elapsed
    import pvt_pkg::*;
#(
    parameter int TIME_BITS        = DEF_TIME_BITS,
    parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
) (
    input  logic [TIME_BITS-1:0] i_now,
    input  logic [TIME_BITS-1:0] i_since,
    input  logic [SEC_W-1:0]     i_seconds,
    output logic                 o_met
);

    localparam int CMP_W = (TIME_BITS > NEED_W) ? TIME_BITS : NEED_W;

    logic [TIME_BITS-1:0] w_diff;
    logic [NEED_W-1:0]    w_need;

    // difference wraps modulo 2^TIME_BITS
    assign w_diff = i_now - i_since;

    // duration in ticks, constant multiplier
    assign w_need = NEED_W'(i_seconds) * NEED_W'(TICKS_PER_SECOND);

    assign o_met = CMP_W'(w_diff) >= CMP_W'(w_need);

endmodule

// File: src/presence_validation_trigger.sv
// presence_validation_trigger: top level, record accumulation and phase machine
// depends on pvt_pkg and pvt_elapsed
//
// order: an accepted frame-end beat is registered in the input register, evaluated
// from it once it drains, and its result is presented from the result register
// throughput: one beat per cycle; records always leave the input register, frame
// ends only when the result register is free or being taken
// reset: synchronous active-low; state and configuration registers return to their defaults, phase idle
module presence_validation_trigger
    import pvt_pkg::*;
#(
    parameter int TIME_BITS        = DEF_TIME_BITS,
    parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE       = 2'd0,
        PH_VALIDATING = 2'd1,
        PH_COOLDOWN   = 2'd2
    } t_phase;

    // configuration registers
    logic [SCORE_W-1:0] r_score_thr;
    logic [CLASS_W-1:0] r_target;
    logic [SEC_W-1:0]   r_validate_s;
    logic [SEC_W-1:0]   r_debounce_s;
    logic [SEC_W-1:0]   r_cooldown_s;

    // input and result stages
    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;
    logic      n_out_valid;
    t_out_beat n_out;

    // trigger state
    t_phase               r_phase, n_phase;
    logic [TIME_BITS-1:0] r_start, n_start;
    logic [TIME_BITS-1:0] r_last, n_last;
    logic                 r_pending, n_pending;
    logic [KIND_W-1:0]    r_seen_kind, n_seen_kind;
    logic                 r_has_kind, n_has_kind;
    logic [COUNT_W-1:0]   r_matches, n_matches;

    logic                 w_advance;
    logic                 w_is_frame;
    logic [63:0]          w_time_ext;
    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_eff_start;
    logic [TIME_BITS-1:0] w_since;
    logic [SEC_W-1:0]     w_seconds;
    logic                 w_met;
    logic                 w_present;
    logic                 w_take;
    logic                 w_hit;
    logic                 w_wake;

    // handshake: input stage moves on when its result has somewhere to go
    assign w_is_frame  = (r_in.mode == MODE_FRAME_END);
    assign w_advance   = r_in_valid && (!w_is_frame || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // frame timestamp reduced to the timer width
    assign w_time_ext = 64'(r_in.time_us);
    assign w_now      = w_time_ext[TIME_BITS-1:0];

    assign w_present   = (r_matches != '0);
    assign w_eff_start = r_pending ? w_now : r_start;

    // one shared duration check, selected by phase
    always_comb begin
        w_since   = w_eff_start;
        w_seconds = r_cooldown_s;
        if (r_phase == PH_VALIDATING) begin
            if (w_present) begin
                w_seconds = r_validate_s;
            end else begin
                w_since   = r_last;
                w_seconds = r_debounce_s;
            end
        end
    end

    pvt_elapsed #(
        .TIME_BITS        (TIME_BITS),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_elapsed (
        .i_now     (w_now),
        .i_since   (w_since),
        .i_seconds (w_seconds),
        .o_met     (w_met)
    );

    // record acceptance rules
    assign w_take = (r_in.record_kind != KIND_INVALID)
                 && (!r_has_kind || (r_seen_kind == r_in.record_kind))
                 && !((r_in.record_kind == KIND_BOX) && w_present);
    assign w_hit  = (r_in.record_target == r_target) && (r_in.record_score > r_score_thr);

    // next state for records and frame ends
    always_comb begin
        n_phase     = r_phase;
        n_start     = r_start;
        n_last      = r_last;
        n_pending   = r_pending;
        n_seen_kind = r_seen_kind;
        n_has_kind  = r_has_kind;
        n_matches   = r_matches;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_wake      = 1'b0;
        if (w_advance) begin
            if (!w_is_frame) begin
                // detection record
                if (r_in.record_kind != KIND_INVALID && !r_has_kind) begin
                    n_has_kind  = 1'b1;
                    n_seen_kind = r_in.record_kind;
                end
                if (w_take && w_hit && r_matches != COUNT_MAX) begin
                    n_matches = r_matches + 1'b1;
                end
            end else begin
                // end of frame: pending cooldown start, then phase step
                n_start   = w_eff_start;
                n_pending = 1'b0;
                case (r_phase)
                    PH_VALIDATING: begin
                        if (w_present) begin
                            n_last = w_now;
                            w_wake = w_met;
                        end else if (w_met) begin
                            n_phase = PH_IDLE;
                            n_last  = '0;
                        end
                    end
                    PH_COOLDOWN: begin
                        if (!w_present && w_met) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        if (w_present) begin
                            n_phase = PH_VALIDATING;
                            n_start = w_now;
                            n_last  = w_now;
                        end
                    end
                endcase
                if (w_wake) begin
                    n_phase   = PH_COOLDOWN;
                    n_pending = 1'b1;
                end
                n_out_valid       = 1'b1;
                n_out.wake        = w_wake;
                n_out.frame_kind  = r_has_kind ? r_seen_kind : KIND_BOX;
                n_out.match_count = r_matches;
                n_out.phase       = PHASE_W'(n_phase);
                // clear frame accumulation
                n_seen_kind = KIND_BOX;
                n_has_kind  = 1'b0;
                n_matches   = '0;
            end
        end
    end

    // state, stages and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_thr  <= RST_SCORE_THRESHOLD;
            r_target     <= RST_TARGET_CLASS;
            r_validate_s <= RST_VALIDATE_SECONDS;
            r_debounce_s <= RST_DEBOUNCE_SECONDS;
            r_cooldown_s <= RST_COOLDOWN_SECONDS;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_IDLE;
            r_start      <= '0;
            r_last       <= '0;
            r_pending    <= 1'b0;
            r_seen_kind  <= KIND_BOX;
            r_has_kind   <= 1'b0;
            r_matches    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SCORE_THRESHOLD:  r_score_thr  <= i_cfg_data[SCORE_W-1:0];
                    CFG_TARGET_CLASS:     r_target     <= i_cfg_data[CLASS_W-1:0];
                    CFG_VALIDATE_SECONDS: r_validate_s <= i_cfg_data[SEC_W-1:0];
                    CFG_DEBOUNCE_SECONDS: r_debounce_s <= i_cfg_data[SEC_W-1:0];
                    CFG_COOLDOWN_SECONDS: r_cooldown_s <= i_cfg_data[SEC_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
            r_start     <= n_start;
            r_last      <= n_last;
            r_pending   <= n_pending;
            r_seen_kind <= n_seen_kind;
            r_has_kind  <= n_has_kind;
            r_matches   <= n_matches;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    // a waking frame always reports cooldown
    a_wake_cooldown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.wake |-> o_out_data.phase == PHASE_W'(PH_COOLDOWN))
        else $error("wake reported outside cooldown");

    // a pending cooldown start only exists while in cooldown
    a_pending_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> r_phase == PH_COOLDOWN)
        else $error("cooldown pending outside cooldown");

    // frame accumulation is empty after a frame end
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && w_is_frame |=> r_matches == '0 && !r_has_kind)
        else $error("frame state not cleared");

    // a result that is not taken stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped while stalled");
`endif

endmodule

// File: dv/presence_validation_trigger_tb.sv
// presence_validation_trigger_tb: self-checking bench for the presence validation trigger
// mirrors record matching, frame accumulation and the idle/validating/cooldown machine
// depends on pvt_pkg and presence_validation_trigger
module presence_validation_trigger_tb
    import pvt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICKS_PER_SEC = DEF_TICKS_PER_SECOND;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 165;
    localparam int SAT_PHASE     = 3;
    localparam int SAT_RECORDS   = 258;
    localparam int DRAIN_CYCLES  = 8;
    localparam int QUIET_LIMIT   = 400;
    localparam int REPORT_MAX    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_COOLDOWN_SECONDS + 3'd1;

    typedef enum logic [PHASE_W-1:0] {
        ST_IDLE       = 2'd0,
        ST_VALIDATING = 2'd1,
        ST_COOLDOWN   = 2'd2
    } t_watch_state;

    // dut ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_beat              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_beat             o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // register mirror
    logic [SCORE_W-1:0] cfg_threshold = RST_SCORE_THRESHOLD;
    logic [CLASS_W-1:0] cfg_target    = RST_TARGET_CLASS;
    logic [SEC_W-1:0]   cfg_validate  = RST_VALIDATE_SECONDS;
    logic [SEC_W-1:0]   cfg_debounce  = RST_DEBOUNCE_SECONDS;
    logic [SEC_W-1:0]   cfg_cooldown  = RST_COOLDOWN_SECONDS;

    // mirrored block state
    t_watch_state         watch_state    = ST_IDLE;
    logic [TIME_US_W-1:0] watch_start_us = '0;
    logic [TIME_US_W-1:0] last_seen_us   = '0;
    logic                 cooldown_armed = 1'b0;
    logic [KIND_W-1:0]    frame_kind     = KIND_BOX;
    logic                 frame_kind_set = 1'b0;
    logic [COUNT_W-1:0]   frame_hits     = '0;

    t_in_beat  pending_beats[$];
    t_out_beat expected_verdicts[$];

    logic in_fire, out_fire;
    logic in_took  = 1'b0;
    logic out_took = 1'b0;
    int   send_gap    = 0;
    int   send_burst  = 0;
    int   recv_stall  = 0;
    int   recv_burst  = 0;
    int   quiet_cycles = 0;
    int   fail_count  = 0;

    // stimulus bookkeeping
    logic [TIME_US_W-1:0] stamp_us;
    logic [TIME_US_W-1:0] quarter_us;
    int                   made;
    int                   run_left;
    bit                   run_hit;
    int                   ph;
    int                   n_sat;
    int                   max_sec;

    presence_validation_trigger u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    assign in_fire  = i_rst_n && i_in_valid && o_in_ready;
    assign out_fire = i_rst_n && o_out_valid && i_out_ready;

    function automatic logic [TIME_US_W-1:0] rand_stamp();
        return {16'($urandom), $urandom};
    endfunction

    // wrap-around duration test
    function automatic logic span_met(input logic [TIME_US_W-1:0] now,
                                      input logic [TIME_US_W-1:0] since,
                                      input logic [SEC_W-1:0] secs);
        logic [TIME_US_W-1:0] diff;
        logic [TIME_US_W-1:0] need;
        diff = now - since;
        need = secs;
        need = need * TICKS_PER_SEC;
        return diff >= need;
    endfunction

    // advance the mirror by one accepted beat
    task automatic track_beat(input t_in_beat b);
        logic                 seen;
        logic                 wake_now;
        logic [TIME_US_W-1:0] now;
        t_out_beat            v;
        if (b.mode == MODE_RECORD) begin
            if (b.record_kind != KIND_INVALID) begin
                if (!frame_kind_set) begin
                    frame_kind_set = 1'b1;
                    frame_kind = b.record_kind;
                end
                if (frame_kind == b.record_kind
                        && !(b.record_kind == KIND_BOX && frame_hits != 0)
                        && b.record_target == cfg_target
                        && b.record_score > cfg_threshold
                        && frame_hits != COUNT_MAX) begin
                    frame_hits = frame_hits + 1'b1;
                end
            end
        end else begin
            now = b.time_us;
            seen = frame_hits != 0;
            wake_now = 1'b0;
            // cooldown timer starts on the frame after a wake
            if (cooldown_armed) begin
                watch_start_us = now;
                cooldown_armed = 1'b0;
            end
            case (watch_state)
                ST_VALIDATING: begin
                    if (seen) begin
                        last_seen_us = now;
                        if (span_met(now, watch_start_us, cfg_validate)) begin
                            wake_now = 1'b1;
                        end
                    end else if (span_met(now, last_seen_us, cfg_debounce)) begin
                        watch_state = ST_IDLE;
                        last_seen_us = '0;
                    end
                end
                ST_COOLDOWN: begin
                    if (!seen && span_met(now, watch_start_us, cfg_cooldown)) begin
                        watch_state = ST_IDLE;
                    end
                end
                default: begin
                    watch_state = ST_IDLE;
                    if (seen) begin
                        watch_state = ST_VALIDATING;
                        watch_start_us = now;
                        last_seen_us = now;
                    end
                end
            endcase
            if (wake_now) begin
                watch_state = ST_COOLDOWN;
                cooldown_armed = 1'b1;
            end
            v.wake = wake_now;
            v.frame_kind = frame_kind_set ? frame_kind : KIND_BOX;
            v.match_count = frame_hits;
            v.phase = watch_state;
            expected_verdicts.push_back(v);
            frame_kind = KIND_BOX;
            frame_kind_set = 1'b0;
            frame_hits = '0;
        end
    endtask

    // compare one result beat with the oldest expectation
    task automatic check_verdict(input t_out_beat got);
        t_out_beat want;
        if (expected_verdicts.size() == 0) begin
            if (fail_count < REPORT_MAX) begin
                $display("unexpected result: wake=%0d kind=%0d count=%0d phase=%0d",
                         got.wake, got.frame_kind, got.match_count, got.phase);
            end
            fail_count++;
        end else begin
            want = expected_verdicts.pop_front();
            if (got.wake !== want.wake || got.frame_kind !== want.frame_kind
                    || got.match_count !== want.match_count || got.phase !== want.phase) begin
                if (fail_count < REPORT_MAX) begin
                    $display({"mismatch: expected wake=%0d kind=%0d count=%0d phase=%0d,",
                              " got wake=%0d kind=%0d count=%0d phase=%0d"},
                             want.wake, want.frame_kind, want.match_count, want.phase,
                             got.wake, got.frame_kind, got.match_count, got.phase);
                end
                fail_count++;
            end
        end
    endtask

    // sample both handshakes
    always @(posedge i_clk) begin
        in_took  <= in_fire;
        out_took <= out_fire;
        if (in_fire) begin
            track_beat(i_in_data);
        end
        if (out_fire) begin
            check_verdict(o_out_data);
        end
    end

    // input driver with per-beat gaps and gapless bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_took) begin
            if (send_gap != 0 || pending_beats.size() == 0) begin
                if (send_gap != 0) begin
                    send_gap--;
                end
                i_in_valid <= 1'b0;
            end else begin
                i_in_data  <= pending_beats.pop_front();
                i_in_valid <= 1'b1;
                if (send_burst != 0) begin
                    send_burst--;
                    send_gap = 0;
                end else begin
                    send_gap = $urandom_range(0, 3);
                    if ($urandom_range(0, 24) == 0) begin
                        send_burst = $urandom_range(20, 60);
                    end
                end
            end
        end
    end

    // result side backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (out_took) begin
                if (recv_burst != 0) begin
                    recv_burst--;
                    recv_stall = 0;
                end else begin
                    recv_stall = $urandom_range(0, 3);
                    if ($urandom_range(0, 24) == 0) begin
                        recv_burst = $urandom_range(20, 60);
                    end
                end
            end
            if (recv_stall != 0) begin
                recv_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (in_fire || out_fire) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_beat rec(input logic [KIND_W-1:0] kind,
                                     input logic [CLASS_W-1:0] tgt,
                                     input logic [SCORE_W-1:0] score);
        t_in_beat b;
        b.mode = MODE_RECORD;
        b.record_kind = kind;
        b.record_target = tgt;
        b.record_score = score;
        b.time_us = rand_stamp();
        return b;
    endfunction

    function automatic t_in_beat frame_end(input logic [TIME_US_W-1:0] stamp);
        t_in_beat b;
        b.mode = MODE_FRAME_END;
        b.record_kind = KIND_W'($urandom);
        b.record_target = CLASS_W'($urandom);
        b.record_score = SCORE_W'($urandom);
        b.time_us = stamp;
        return b;
    endfunction

    function automatic logic [SCORE_W-1:0] score_above();
        if (cfg_threshold == '1) begin
            return '1;
        end
        if ($urandom_range(0, 1) == 0) begin
            return cfg_threshold + 1'b1;
        end
        return SCORE_W'($urandom_range(cfg_threshold + 1, 127));
    endfunction

    function automatic logic [SCORE_W-1:0] score_not_above();
        if ($urandom_range(0, 1) == 0) begin
            return cfg_threshold;
        end
        return SCORE_W'($urandom_range(0, cfg_threshold));
    endfunction

    // time step: whole quarters of the phase scale, sometimes off by one or a wild jump
    function automatic logic [TIME_US_W-1:0] next_step();
        int                   pick;
        logic [TIME_US_W-1:0] d;
        pick = $urandom_range(0, 99);
        d = quarter_us * $urandom_range(0, 4);
        if (pick < 8) begin
            d = d + 1'b1;
        end else if (pick < 16 && d != 0) begin
            d = d - 1'b1;
        end else if (pick < 18) begin
            d = rand_stamp();
        end
        return d;
    endfunction

    // one frame of records then its frame end
    task automatic queue_frame(input bit want_match);
        int                n_rec;
        int                hit_at;
        int                i;
        logic [KIND_W-1:0] kind;
        logic [KIND_W-1:0] k;
        logic [CLASS_W-1:0] tgt;
        logic [SCORE_W-1:0] sc;
        n_rec = $urandom_range(0, 5);
        if (want_match && n_rec == 0) begin
            n_rec = 1;
        end
        hit_at = want_match ? $urandom_range(0, n_rec - 1) : -1;
        kind = KIND_W'($urandom_range(0, 2));
        for (i = 0; i < n_rec; i++) begin
            k = kind;
            tgt = cfg_target;
            sc = score_above();
            if (i != hit_at) begin
                if ($urandom_range(0, 9) == 0) begin
                    k = KIND_W'($urandom_range(0, 3));
                end
                if ($urandom_range(0, 1) == 0) begin
                    tgt = CLASS_W'($urandom);
                end
                if ($urandom_range(0, 19) == 0) begin
                    sc = SCORE_W'($urandom);
                end else if (!want_match && tgt == cfg_target) begin
                    sc = score_not_above();
                end
            end
            pending_beats.push_back(rec(k, tgt, sc));
            made++;
        end
        stamp_us = stamp_us + next_step();
        pending_beats.push_back(frame_end(stamp_us));
        made++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_SCORE_THRESHOLD:  cfg_threshold = data[SCORE_W-1:0];
            CFG_TARGET_CLASS:     cfg_target = data[CLASS_W-1:0];
            CFG_VALIDATE_SECONDS: cfg_validate = data[SEC_W-1:0];
            CFG_DEBOUNCE_SECONDS: cfg_debounce = data[SEC_W-1:0];
            CFG_COOLDOWN_SECONDS: cfg_cooldown = data[SEC_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] tgt,
                            input logic [CFG_DATA_W-1:0] val, input logic [CFG_DATA_W-1:0] deb,
                            input logic [CFG_DATA_W-1:0] cool);
        write_reg(CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom));
        write_reg(CFG_SCORE_THRESHOLD, thr);
        write_reg(CFG_TARGET_CLASS, tgt);
        write_reg(CFG_VALIDATE_SECONDS, val);
        write_reg(CFG_DEBOUNCE_SECONDS, deb);
        write_reg(CFG_COOLDOWN_SECONDS, cool);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // all beats sent, all results back, then let the pipeline settle
    task automatic wait_idle();
        while (pending_beats.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (expected_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_in_beat loud;

        // directed frames under reset register values
        pending_beats.push_back(frame_end('0));
        pending_beats.push_back(rec(KIND_INVALID, 8'd0, 7'd127));
        pending_beats.push_back(frame_end('0));
        // box frame: only the first matching box counts
        pending_beats.push_back(rec(KIND_BOX, 8'd1, 7'd127));
        pending_beats.push_back(rec(KIND_BOX, 8'd0, 7'd76));
        pending_beats.push_back(rec(KIND_BOX, 8'd0, 7'd127));
        pending_beats.push_back(frame_end(48'd500000));
        // class frame: score equal to threshold misses, other kinds ignored
        pending_beats.push_back(rec(KIND_CLASS, 8'd0, 7'd75));
        pending_beats.push_back(rec(KIND_CLASS, 8'd0, 7'd127));
        pending_beats.push_back(rec(KIND_BOX, 8'd0, 7'd127));
        pending_beats.push_back(rec(KIND_KEYPOINT, 8'd0, 7'd100));
        pending_beats.push_back(rec(KIND_CLASS, 8'd0, 7'd76));
        pending_beats.push_back(frame_end(48'd1500000));
        // keypoint frame reaching the validate time exactly
        pending_beats.push_back(rec(KIND_KEYPOINT, 8'd255, 7'd127));
        pending_beats.push_back(rec(KIND_KEYPOINT, 8'd0, 7'd0));
        pending_beats.push_back(rec(KIND_KEYPOINT, 8'd0, 7'd120));
        pending_beats.push_back(frame_end(48'd2500000));
        // frame end with every record field high, cooldown starts at the top of time
        loud.mode = MODE_FRAME_END;
        loud.record_kind = KIND_INVALID;
        loud.record_target = '1;
        loud.record_score = '1;
        loud.time_us = '1;
        pending_beats.push_back(loud);
        // cooldown ends exactly across the wrap
        pending_beats.push_back(frame_end(48'd7999999));
        // debounce: one tick short, then exact
        pending_beats.push_back(rec(KIND_CLASS, 8'd0, 7'd127));
        pending_beats.push_back(frame_end(48'd8000000));
        pending_beats.push_back(frame_end(48'd8999999));
        pending_beats.push_back(frame_end(48'd9000000));

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        // random phases across register settings
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_regs(8'd0, 8'd255, 8'd0, 8'd0, 8'd0);
                1: set_regs(8'd100, 8'd0, 8'd60, 8'd60, 8'd60);
                2: set_regs(8'h85, CFG_DATA_W'($urandom), 8'hFF, 8'h41, 8'hC0);
                4: set_regs(8'd127, CFG_DATA_W'($urandom), 8'd1, 8'd0, 8'd2);
                default: set_regs(CFG_DATA_W'($urandom_range(0, 100)), CFG_DATA_W'($urandom),
                                  CFG_DATA_W'($urandom_range(0, 6)),
                                  CFG_DATA_W'($urandom_range(0, 4)),
                                  CFG_DATA_W'($urandom_range(0, 10)));
            endcase
            max_sec = cfg_validate;
            if (cfg_debounce > max_sec) max_sec = cfg_debounce;
            if (cfg_cooldown > max_sec) max_sec = cfg_cooldown;
            quarter_us = TIME_US_W'(TICKS_PER_SEC / 4);
            if (max_sec >= 8) begin
                quarter_us = quarter_us * TIME_US_W'(max_sec / 4);
            end
            stamp_us = (ph == 5) ? 48'hFFFF_FFFF_FFFF - 48'd20000000 : rand_stamp();
            made = 0;
            run_left = 0;
            // one frame of class matches past the count ceiling
            if (ph == SAT_PHASE) begin
                for (n_sat = 0; n_sat < SAT_RECORDS; n_sat++) begin
                    pending_beats.push_back(rec(KIND_CLASS, cfg_target, '1));
                    made++;
                end
                stamp_us = stamp_us + next_step();
                pending_beats.push_back(frame_end(stamp_us));
                made++;
            end
            while (made < PHASE_ITEMS) begin
                if (run_left == 0) begin
                    run_hit = $urandom_range(0, 1);
                    run_left = run_hit ? $urandom_range(4, 20) : $urandom_range(1, 10);
                end
                run_left--;
                queue_frame(run_hit);
            end
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/pvt_pkg.sv
src/pvt_elapsed.sv
src/presence_validation_trigger.sv
dv/presence_validation_trigger_tb.sv
